// ----- rtl/adlp_pkg.sv -----
`default_nettype none

package adlp_pkg;

	// Fixed-point layout
	localparam int SAMPLE_BITS = 12;
	localparam int FRAC_BITS   = 16;
	localparam int NORM_BITS   = 10;
	localparam int DUTY_BITS   = 8;
	localparam int ALPHA_BITS  = 16;

	localparam int AVG_BITS      = SAMPLE_BITS + FRAC_BITS;
	localparam int PROD_BITS     = AVG_BITS + 1 + ALPHA_BITS + 1;
	localparam int NORM_SHIFT    = FRAC_BITS - NORM_BITS;
	localparam int DIVIDEND_BITS = AVG_BITS + 1 - NORM_SHIFT;
	localparam int QUOT_BITS     = NORM_BITS + 1;
	localparam int CNT_BITS      = $clog2(ALPHA_BITS);
	localparam int DUTY_MAX      = (1 << DUTY_BITS) - 1;

	localparam logic [QUOT_BITS-1:0] NORM_ONE = QUOT_BITS'(1 << NORM_BITS);

	// Stream and configuration port widths
	localparam int IN_TDATA_BITS  = ((SAMPLE_BITS + 7) / 8) * 8;
	localparam int OUT_BITS       = 2 * DUTY_BITS + 3 * SAMPLE_BITS;
	localparam int OUT_TDATA_BITS = ((OUT_BITS + 7) / 8) * 8;
	localparam int CFG_INDEX_BITS = 3;
	localparam int CFG_DATA_BITS  = ALPHA_BITS;

	// Register indexes
	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_INVERT    = 3'd0,
		REG_ALPHA     = 3'd1,
		REG_MIN_SPAN  = 3'd2,
		REG_STEP_UP   = 3'd3,
		REG_STEP_DOWN = 3'd4
	} cfg_reg_t;

	// Sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_NORM,
		ST_SPAN,
		ST_DIV,
		ST_GAMMA,
		ST_DONE
	} state_t;

	// Divider request and response
	typedef struct packed {
		logic                     start;
		logic [DIVIDEND_BITS-1:0] dividend;
		logic [SAMPLE_BITS-1:0]   divisor;
	} div_req_t;

	typedef struct packed {
		logic                 done;
		logic [QUOT_BITS-1:0] quot;
	} div_rsp_t;

	// Gamma 1/1.4 written as exponent 5/7
	localparam int GAMMA_NUM = 5;
	localparam int GAMMA_DEN = 7;
	localparam int GAMMA_W   = 192;

	typedef logic [DUTY_MAX:0][QUOT_BITS-1:0] gamma_thr_t;

	function automatic logic [GAMMA_W-1:0] ipow(logic [GAMMA_W-1:0] b, int e);
		logic [GAMMA_W-1:0] r;
		r = GAMMA_W'(1);
		for (int i = 0; i < e; i++) begin
			r = r * b;
		end
		return r;
	endfunction

	// Smallest normalized value that reaches each duty after rounding:
	// duty d holds when (2d-1)^7 * 2^(5N) <= (2*DUTY_MAX)^7 * n^5
	function automatic gamma_thr_t build_gamma_thr();
		gamma_thr_t           t;
		logic [GAMMA_W-1:0]   scale;
		logic [GAMMA_W-1:0]   lhs;
		logic [GAMMA_W-1:0]   f;
		logic [QUOT_BITS-1:0] n;
		logic [QUOT_BITS-1:0] trial;
		scale = ipow(GAMMA_W'(2 * DUTY_MAX), GAMMA_DEN);
		t[0]  = '0;
		for (int d = 1; d <= DUTY_MAX; d++) begin
			lhs = ipow(GAMMA_W'(2 * d - 1), GAMMA_DEN) << (GAMMA_NUM * NORM_BITS);
			n   = '0;
			for (int b = NORM_BITS; b >= 0; b--) begin
				trial = n | (QUOT_BITS'(1) << b);
				f     = scale * ipow(GAMMA_W'(trial), GAMMA_NUM);
				if (trial <= NORM_ONE && f < lhs) begin
					n = trial;
				end
			end
			t[d] = n + QUOT_BITS'(1);
		end
		return t;
	endfunction

	localparam gamma_thr_t GAMMA_THR = build_gamma_thr();

endpackage

`default_nettype wire

// ----- rtl/adlp_div.sv -----
`default_nettype none

// Restoring divider, one quotient bit per cycle; quotient capped at one
module adlp_div (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire adlp_pkg::div_req_t req,
	output adlp_pkg::div_rsp_t      rsp
);

	logic                                busy_q;
	logic                                done_q;
	logic [adlp_pkg::CNT_BITS-1:0]       cnt_q;
	logic [adlp_pkg::SAMPLE_BITS-1:0]    rem_q;
	logic [adlp_pkg::SAMPLE_BITS-1:0]    divisor_q;
	logic [adlp_pkg::QUOT_BITS-1:0]      sh_q;
	logic                                sat_q;

	logic [adlp_pkg::SAMPLE_BITS:0]      trial;
	logic [adlp_pkg::SAMPLE_BITS:0]      trial_sub;
	logic                                fits;
	logic [adlp_pkg::SAMPLE_BITS-1:0]    rem_next;

	// Shift in the next dividend bit and try the subtract
	always_comb begin
		trial     = {rem_q, sh_q[adlp_pkg::QUOT_BITS-1]};
		fits      = trial >= {1'b0, divisor_q};
		trial_sub = trial - {1'b0, divisor_q};
		rem_next  = fits ? trial_sub[adlp_pkg::SAMPLE_BITS-1:0]
		                 : trial[adlp_pkg::SAMPLE_BITS-1:0];
	end

	// Control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= adlp_pkg::CNT_BITS'(adlp_pkg::QUOT_BITS - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - adlp_pkg::CNT_BITS'(1);
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: quotient bits replace dividend bits in the shift register
	always_ff @(posedge clk) begin
		if (req.start) begin
			divisor_q <= req.divisor;
			sat_q     <= req.dividend >= {req.divisor, {adlp_pkg::QUOT_BITS{1'b0}}};
			rem_q     <= req.dividend[adlp_pkg::DIVIDEND_BITS-1:adlp_pkg::QUOT_BITS];
			sh_q      <= req.dividend[adlp_pkg::QUOT_BITS-1:0];
		end else if (busy_q) begin
			rem_q <= rem_next;
			sh_q  <= {sh_q[adlp_pkg::QUOT_BITS-2:0], fits};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = (sat_q || sh_q > adlp_pkg::NORM_ONE) ? adlp_pkg::NORM_ONE : sh_q;

endmodule

`default_nettype wire

// ----- rtl/auto_dimming_light_to_pwm.sv -----
`default_nettype none

// Auto-dimming light sensor to lamp PWM duty.
// s_axis carries one 12-bit light reading per request in tdata[11:0]. Each
// request gives one result on m_axis: slew-limited duty, gamma target duty,
// smoothed level and the learned low and high levels.
// Configuration is written through cfg_wen / cfg_index / cfg_wdata; the user
// must write it only while idle, and the block itself does not enforce this.
// The main work for each request is the serial moving-average multiply (one
// alpha bit a cycle), the serial normalizing divide of 11 quotient bits and
// the bit-by-bit gamma table search over the 8 duty bits, done in that order;
// a new request is taken only when the last one has finished these steps.
// The result sits in an output register; a new request is taken while it
// waits. If the receiver still stalls when the next result is finished, the
// sequencer holds in its last step until the register is free.
// Reset clears the average, the learned range (low 4095, high 0), the duty
// and the first-sample flags, and sets the registers to their defaults.
module auto_dimming_light_to_pwm (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 s_axis_tvalid,
	output logic                                      s_axis_tready,
	// [11:0] light_sample
	input  wire logic [adlp_pkg::IN_TDATA_BITS-1:0]   s_axis_tdata,
	output logic                                      m_axis_tvalid,
	input  wire logic                                 m_axis_tready,
	// [7:0] duty_drive, [15:8] duty_target, [27:16] smoothed_level,
	// [39:28] learned_low, [51:40] learned_high
	output logic [adlp_pkg::OUT_TDATA_BITS-1:0]       m_axis_tdata,
	input  wire logic                                 cfg_wen,
	input  wire logic [adlp_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
	input  wire logic [adlp_pkg::CFG_DATA_BITS-1:0]   cfg_wdata
);

	localparam int SB = adlp_pkg::SAMPLE_BITS;
	localparam int FB = adlp_pkg::FRAC_BITS;
	localparam int AB = adlp_pkg::AVG_BITS;
	localparam int PB = adlp_pkg::PROD_BITS;
	localparam int DB = adlp_pkg::DUTY_BITS;
	localparam int QB = adlp_pkg::QUOT_BITS;
	localparam int CB = adlp_pkg::CNT_BITS;
	localparam int WB = adlp_pkg::ALPHA_BITS;
	localparam logic signed [PB-1:0] ROUND = PB'(1 << (WB - 1));

	adlp_pkg::state_t state_q, state_d;

	// Configuration registers
	logic          invert_q;
	logic [WB-1:0] alpha_q;
	logic [SB-1:0] min_span_q;
	logic [DB-1:0] step_up_q;
	logic [DB-1:0] step_down_q;

	// Block state
	logic [AB-1:0] avg_q;
	logic          avg_seeded_q;
	logic [SB-1:0] low_q;
	logic [SB-1:0] high_q;
	logic [DB-1:0] duty_q;
	logic          duty_seeded_q;

	// Working registers
	logic signed [AB:0]   diff_q;
	logic [WB-1:0]        alpha_sh_q;
	logic signed [PB-1:0] prod_q;
	logic [CB-1:0]        cnt_q;
	logic [QB-1:0]        norm_q;
	logic [DB-1:0]        dsel_q;

	// Output register
	logic          out_valid_q;
	logic [DB-1:0] out_drive_q;
	logic [DB-1:0] out_target_q;
	logic [SB-1:0] out_level_q;
	logic [SB-1:0] out_low_q;
	logic [SB-1:0] out_high_q;

	// Control strobes
	logic accept;
	logic load_out;

	// Datapath
	logic [SB-1:0]        sample;
	logic [AB-1:0]        sq;
	logic [AB-1:0]        avg_base;
	logic signed [PB-1:0] prod_next;
	logic signed [PB-1:0] rnd;
	logic [AB-1:0]        avg_new;
	logic [SB-1:0]        level_new;
	logic [SB-1:0]        span_raw;
	logic [SB-1:0]        span;
	logic [AB-1:0]        low_frac;
	logic [AB-1:0]        num;
	logic [AB:0]          ysum;
	logic [DB-1:0]        trial;
	logic [DB-1:0]        target;
	logic [DB-1:0]        step;
	logic [DB-1:0]        duty_next;

	adlp_pkg::div_req_t div_req;
	adlp_pkg::div_rsp_t div_rsp;

	// Sequencer
	always_comb begin
		state_d  = state_q;
		accept   = 1'b0;
		load_out = 1'b0;
		case (state_q)
			adlp_pkg::ST_IDLE: begin
				accept = s_axis_tvalid;
				if (s_axis_tvalid) begin
					state_d = adlp_pkg::ST_MUL;
				end
			end
			adlp_pkg::ST_MUL: begin
				if (cnt_q == '0) begin
					state_d = adlp_pkg::ST_NORM;
				end
			end
			adlp_pkg::ST_NORM: state_d = adlp_pkg::ST_SPAN;
			adlp_pkg::ST_SPAN: state_d = adlp_pkg::ST_DIV;
			adlp_pkg::ST_DIV: begin
				if (div_rsp.done) begin
					state_d = adlp_pkg::ST_GAMMA;
				end
			end
			adlp_pkg::ST_GAMMA: begin
				if (cnt_q == '0) begin
					state_d = adlp_pkg::ST_DONE;
				end
			end
			adlp_pkg::ST_DONE: begin
				if (!out_valid_q || m_axis_tready) begin
					load_out = 1'b1;
					state_d  = adlp_pkg::ST_IDLE;
				end
			end
			default: state_d = adlp_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= adlp_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign s_axis_tready = (state_q == adlp_pkg::ST_IDLE);

	// Seed the average with the first sample
	always_comb begin
		sample   = s_axis_tdata[SB-1:0];
		sq       = {sample, {FB{1'b0}}};
		avg_base = avg_seeded_q ? avg_q : sq;
	end

	// One alpha bit per cycle, most significant first
	assign prod_next = (prod_q <<< 1) + (alpha_sh_q[WB-1] ? PB'(diff_q) : '0);

	// Round the weighted step and apply it
	always_comb begin
		rnd       = (prod_q + ROUND) >>> WB;
		avg_new   = avg_q + rnd[AB-1:0];
		level_new = avg_new[AB-1:FB];
	end

	// Span with floor, offset above the low level, prescaled dividend
	always_comb begin
		span_raw = (high_q > low_q) ? (high_q - low_q) : '0;
		span     = (span_raw < min_span_q) ? min_span_q : span_raw;
		if (span == '0) begin
			span = SB'(1);
		end
		low_frac = {low_q, {FB{1'b0}}};
		num      = (avg_q > low_frac) ? (avg_q - low_frac) : '0;
		ysum     = (AB + 1)'(num) + ((AB + 1)'(span) << (adlp_pkg::NORM_SHIFT - 1));
	end

	always_comb begin
		div_req.start    = (state_q == adlp_pkg::ST_SPAN);
		div_req.dividend = ysum[AB:adlp_pkg::NORM_SHIFT];
		div_req.divisor  = span;
	end

	adlp_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// Gamma search: try each duty bit against the threshold table
	assign trial = dsel_q | (DB'(1) << cnt_q);

	// Slew limit toward the target; the first result takes the target directly
	always_comb begin
		target    = dsel_q;
		step      = '0;
		duty_next = duty_q;
		if (!duty_seeded_q) begin
			duty_next = target;
		end else if (target > duty_q) begin
			step      = target - duty_q;
			duty_next = duty_q + ((step > step_up_q) ? step_up_q : step);
		end else if (target < duty_q) begin
			step      = duty_q - target;
			duty_next = duty_q - ((step > step_down_q) ? step_down_q : step);
		end
	end

	// Configuration, block state and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			invert_q      <= 1'b1;
			alpha_q       <= WB'(328);
			min_span_q    <= SB'(50);
			step_up_q     <= DB'(5);
			step_down_q   <= DB'(4);
			avg_q         <= '0;
			avg_seeded_q  <= 1'b0;
			low_q         <= '1;
			high_q        <= '0;
			duty_q        <= '0;
			duty_seeded_q <= 1'b0;
			out_valid_q   <= 1'b0;
			cnt_q         <= '0;
		end else begin
			if (cfg_wen) begin
				case (cfg_index)
					adlp_pkg::REG_INVERT:    invert_q    <= cfg_wdata[0];
					adlp_pkg::REG_ALPHA:     alpha_q     <= cfg_wdata[WB-1:0];
					adlp_pkg::REG_MIN_SPAN:  min_span_q  <= cfg_wdata[SB-1:0];
					adlp_pkg::REG_STEP_UP:   step_up_q   <= cfg_wdata[DB-1:0];
					adlp_pkg::REG_STEP_DOWN: step_down_q <= cfg_wdata[DB-1:0];
					default: ;
				endcase
			end

			if (accept) begin
				avg_q        <= avg_base;
				avg_seeded_q <= 1'b1;
				cnt_q        <= CB'(WB - 1);
			end else if (state_q == adlp_pkg::ST_MUL) begin
				cnt_q <= cnt_q - CB'(1);
			end else if (state_q == adlp_pkg::ST_NORM) begin
				avg_q <= avg_new;
				if (level_new < low_q) begin
					low_q <= level_new;
				end
				if (level_new > high_q) begin
					high_q <= level_new;
				end
			end else if (state_q == adlp_pkg::ST_DIV && div_rsp.done) begin
				cnt_q <= CB'(DB - 1);
			end else if (state_q == adlp_pkg::ST_GAMMA && cnt_q != '0) begin
				cnt_q <= cnt_q - CB'(1);
			end

			if (load_out) begin
				duty_q        <= duty_next;
				duty_seeded_q <= 1'b1;
				out_valid_q   <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Working and output payload
	always_ff @(posedge clk) begin
		if (accept) begin
			diff_q     <= $signed({1'b0, sq}) - $signed({1'b0, avg_base});
			alpha_sh_q <= alpha_q;
			prod_q     <= '0;
		end else if (state_q == adlp_pkg::ST_MUL) begin
			prod_q     <= prod_next;
			alpha_sh_q <= {alpha_sh_q[WB-2:0], 1'b0};
		end

		if (state_q == adlp_pkg::ST_DIV && div_rsp.done) begin
			norm_q <= invert_q ? (adlp_pkg::NORM_ONE - div_rsp.quot) : div_rsp.quot;
			dsel_q <= '0;
		end else if (state_q == adlp_pkg::ST_GAMMA) begin
			if (norm_q >= adlp_pkg::GAMMA_THR[trial]) begin
				dsel_q <= trial;
			end
		end

		if (load_out) begin
			out_drive_q  <= duty_next;
			out_target_q <= target;
			out_level_q  <= avg_q[AB-1:FB];
			out_low_q    <= low_q;
			out_high_q   <= high_q;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{(adlp_pkg::OUT_TDATA_BITS - adlp_pkg::OUT_BITS){1'b0}},
	                        out_high_q, out_low_q, out_level_q, out_target_q, out_drive_q};

	// Checks
	a_range_order: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> out_low_q <= out_high_q)
		else $error("learned low above learned high");

	a_norm_cap: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == adlp_pkg::ST_GAMMA) |-> norm_q <= adlp_pkg::NORM_ONE)
		else $error("normalized value above one");

	a_seeded_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != adlp_pkg::ST_IDLE) |-> avg_seeded_q)
		else $error("working on an item with an unseeded average");

	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> state_q == adlp_pkg::ST_DIV)
		else $error("divider finished outside the divide step");

endmodule

`default_nettype wire

// ----- tb/sv/auto_dimming_light_to_pwm_tb.sv -----
`timescale 1ns / 1ps

module auto_dimming_light_to_pwm_tb;
	import adlp_pkg::*;

	localparam int HALF_PERIOD   = 2;
	localparam int RESET_CYCLES  = 8;
	localparam int QUIET_LIMIT   = 4000;
	localparam int HOLD_CYCLES   = 400;
	localparam int SETTLE_CYCLES = 100;
	localparam int MAX_REPORTS   = 10;
	localparam int IDLE_PERCENT  = 18;
	localparam int MAX_GAP       = 45;
	localparam int RANDOM_PHASES = 13;
	localparam int PHASE_ITEMS   = 145;
	localparam int HOLD_ITEMS    = 40;
	localparam int NORM_FULL     = 1 << NORM_BITS;
	localparam int MID_LEVEL     = 1 << (SAMPLE_BITS - 1);
	localparam int SAMPLE_TOP    = (1 << SAMPLE_BITS) - 1;

	// Result fields, lowest bits last, laid out as on m_axis_tdata
	typedef struct packed {
		logic [SAMPLE_BITS-1:0] high;
		logic [SAMPLE_BITS-1:0] low;
		logic [SAMPLE_BITS-1:0] level;
		logic [DUTY_BITS-1:0]   target;
		logic [DUTY_BITS-1:0]   drive;
	} dim_result_t;

	logic                      clk           = 1'b0;
	logic                      arst_n        = 1'b0;
	logic                      s_axis_tvalid = 1'b0;
	logic                      s_axis_tready;
	// [11:0] light_sample
	logic [IN_TDATA_BITS-1:0]  s_axis_tdata  = '0;
	logic                      m_axis_tvalid;
	logic                      m_axis_tready = 1'b0;
	// [7:0] duty_drive, [15:8] duty_target, [27:16] smoothed_level,
	// [39:28] learned_low, [51:40] learned_high
	logic [OUT_TDATA_BITS-1:0] m_axis_tdata;
	logic                      cfg_wen       = 1'b0;
	logic [CFG_INDEX_BITS-1:0] cfg_index     = '0;
	logic [CFG_DATA_BITS-1:0]  cfg_wdata     = '0;

	// Register shadows, at their reset values
	logic                   cfg_invert    = 1'b1;
	logic [ALPHA_BITS-1:0]  cfg_alpha     = 16'd328;
	logic [SAMPLE_BITS-1:0] cfg_min_span  = 12'd50;
	logic [DUTY_BITS-1:0]   cfg_step_up   = 8'd5;
	logic [DUTY_BITS-1:0]   cfg_step_down = 8'd4;

	// Dimmer state
	longint unsigned        avg_q       = 0;
	bit                     avg_seeded  = 1'b0;
	logic [SAMPLE_BITS-1:0] level_min   = '1;
	logic [SAMPLE_BITS-1:0] level_max   = '0;
	logic [DUTY_BITS-1:0]   duty_now    = '0;
	bit                     duty_seeded = 1'b0;

	dim_result_t dimmer_results[$];
	int unsigned idle_pct        = IDLE_PERCENT;
	int unsigned hold_asked      = 0;
	int unsigned hold_granted    = 0;
	int unsigned hold_left       = 0;
	int unsigned quiet_cycles    = 0;
	int unsigned errors          = 0;
	int unsigned samples_sent    = 0;
	int unsigned results_checked = 0;

	auto_dimming_light_to_pwm i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_wen       (cfg_wen),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata)
	);

	always #HALF_PERIOD clk = ~clk;

	// Largest duty d with (2d-1)^7 * 2^(5*NORM_BITS) <= (2*DUTY_MAX)^7 * n^5
	function automatic logic [DUTY_BITS-1:0] gamma_duty_of(int unsigned n);
		logic [127:0] bound;
		logic [127:0] trial;
		int unsigned  lo;
		int unsigned  hi;
		int unsigned  mid;
		bound = 128'd1;
		for (int i = 0; i < 7; i++)
			bound = bound * 128'(2 * DUTY_MAX);
		for (int i = 0; i < 5; i++)
			bound = bound * 128'(n);
		lo = 0;
		hi = DUTY_MAX;
		while (lo < hi) begin
			mid   = (lo + hi + 1) / 2;
			trial = 128'd1;
			for (int i = 0; i < 7; i++)
				trial = trial * 128'(2 * mid - 1);
			trial = trial << (5 * NORM_BITS);
			if (trial <= bound)
				lo = mid;
			else
				hi = mid - 1;
		end
		return DUTY_BITS'(lo);
	endfunction

	// Smooth, learn the range, normalize, shape and slew one light sample
	function automatic dim_result_t advance_dimmer(logic [SAMPLE_BITS-1:0] sample);
		longint unsigned scaled;
		longint unsigned weight;
		longint unsigned low_q;
		longint unsigned num;
		longint unsigned den;
		longint unsigned norm;
		int unsigned     level;
		int unsigned     span;
		int unsigned     target;
		dim_result_t     res;
		scaled = 64'(sample) << FRAC_BITS;
		weight = 64'(cfg_alpha);
		if (!avg_seeded) begin
			avg_q      = scaled;
			avg_seeded = 1'b1;
		end
		avg_q = (weight * scaled + ((64'd1 << ALPHA_BITS) - weight) * avg_q
			+ (64'd1 << (ALPHA_BITS - 1))) >> ALPHA_BITS;
		level = 32'((avg_q >> FRAC_BITS) & 64'(SAMPLE_TOP));
		if (level < level_min)
			level_min = SAMPLE_BITS'(level);
		if (level > level_max)
			level_max = SAMPLE_BITS'(level);

		// Divide by the learned span, never below the floor or one
		span = (level_max > level_min) ? 32'(level_max - level_min) : 0;
		if (span < cfg_min_span)
			span = cfg_min_span;
		if (span == 0)
			span = 1;
		low_q = 64'(level_min) << FRAC_BITS;
		num   = (avg_q > low_q) ? avg_q - low_q : 64'd0;
		den   = 64'(span) << FRAC_BITS;
		norm  = ((num << NORM_BITS) + den / 2) / den;
		if (norm > NORM_FULL)
			norm = NORM_FULL;
		if (cfg_invert)
			norm = NORM_FULL - norm;
		target = gamma_duty_of(32'(norm));

		// Take the first target directly, then limit each step
		if (!duty_seeded) begin
			duty_now    = DUTY_BITS'(target);
			duty_seeded = 1'b1;
		end else if (target > duty_now) begin
			if (target - duty_now > cfg_step_up)
				duty_now = duty_now + cfg_step_up;
			else
				duty_now = DUTY_BITS'(target);
		end else if (target < duty_now) begin
			if (duty_now - target > cfg_step_down)
				duty_now = duty_now - cfg_step_down;
			else
				duty_now = DUTY_BITS'(target);
		end

		res.drive  = duty_now;
		res.target = DUTY_BITS'(target);
		res.level  = SAMPLE_BITS'(level);
		res.low    = level_min;
		res.high   = level_max;
		return res;
	endfunction

	function automatic void note_failure(string what);
		errors++;
		if (errors <= MAX_REPORTS)
			$display("[%0t] %s", $realtime, what);
	endfunction

	// Write one register; the shadow follows the same decode
	task automatic write_reg(logic [CFG_INDEX_BITS-1:0] index, logic [CFG_DATA_BITS-1:0] value);
		@(posedge clk);
		cfg_wen   <= 1'b1;
		cfg_index <= index;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_wen <= 1'b0;
		case (index)
			REG_INVERT:    cfg_invert    = value[0];
			REG_ALPHA:     cfg_alpha     = value[ALPHA_BITS-1:0];
			REG_MIN_SPAN:  cfg_min_span  = value[SAMPLE_BITS-1:0];
			REG_STEP_UP:   cfg_step_up   = value[DUTY_BITS-1:0];
			REG_STEP_DOWN: cfg_step_down = value[DUTY_BITS-1:0];
			default: ;
		endcase
	endtask

	task automatic set_config(logic inv, logic [ALPHA_BITS-1:0] alpha,
		logic [SAMPLE_BITS-1:0] span, logic [DUTY_BITS-1:0] up, logic [DUTY_BITS-1:0] down);
		write_reg(REG_INVERT, CFG_DATA_BITS'(inv));
		write_reg(REG_ALPHA, CFG_DATA_BITS'(alpha));
		write_reg(REG_MIN_SPAN, CFG_DATA_BITS'(span));
		write_reg(REG_STEP_UP, CFG_DATA_BITS'(up));
		write_reg(REG_STEP_DOWN, CFG_DATA_BITS'(down));
	endtask

	// Offer one light sample; valid stays high for a following request
	task automatic send_sample(logic [SAMPLE_BITS-1:0] sample);
		int unsigned gap;
		gap = 0;
		if ($urandom_range(99) < idle_pct)
			gap = $urandom_range(1, MAX_GAP);
		if (gap != 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= IN_TDATA_BITS'(sample);
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		dimmer_results.push_back(advance_dimmer(sample));
		samples_sent++;
	endtask

	// Drop valid and wait for every outstanding result
	task automatic drain_results();
		s_axis_tvalid <= 1'b0;
		while (dimmer_results.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic [DUTY_BITS-1:0] pick_step();
		case ($urandom_range(3))
			0:       return '0;
			1:       return '1;
			default: return DUTY_BITS'($urandom_range(1, 40));
		endcase
	endfunction

	// First request seeds the average and the duty; learned span is zero
	task automatic test_first_item();
		send_sample(MID_LEVEL);
		drain_results();
	endtask

	// Zero alpha holds the average, zero floor is forced to one, zero steps freeze
	task automatic test_frozen_corners();
		set_config(1'b0, '0, '0, '0, '0);
		send_sample(SAMPLE_TOP);
		send_sample(0);
		drain_results();
		write_reg(REG_STEP_DOWN, CFG_DATA_BITS'(DUTY_MAX));
		send_sample(0);
		drain_results();
	endtask

	// Unlisted indexes do nothing and upper data bits are dropped
	task automatic test_register_decode();
		for (int idx = REG_STEP_DOWN + 1; idx < (1 << CFG_INDEX_BITS); idx++)
			write_reg(CFG_INDEX_BITS'(idx), '1);
		write_reg(REG_INVERT, 16'hFFFE);
		write_reg(REG_ALPHA, 16'd4000);
		write_reg(REG_MIN_SPAN, 16'hF020);
		write_reg(REG_STEP_UP, 16'hFF07);
		write_reg(REG_STEP_DOWN, 16'hFF06);
		send_sample(12'd2060);
		send_sample(12'd2030);
		drain_results();
	endtask

	// Field extremes and alternating bits at the default settings
	task automatic test_sample_extremes();
		set_config(1'b1, 16'd328, 12'd50, 8'd5, 8'd4);
		send_sample(0);
		send_sample(SAMPLE_TOP);
		send_sample(12'hAAA);
		send_sample(12'h555);
		send_sample(1);
		send_sample(SAMPLE_TOP - 1);
		send_sample(12'h800);
		send_sample(12'h7FF);
		drain_results();
	endtask

	// Largest alpha follows each sample; widest and narrowest floors
	task automatic test_fast_tracking();
		set_config(1'b1, '1, 12'd4095, '1, '1);
		send_sample(12'd2000);
		send_sample(12'd2100);
		send_sample(12'd2048);
		drain_results();
		set_config(1'b0, '1, 12'd1, '1, '1);
		send_sample(12'd2010);
		send_sample(12'd2095);
		send_sample(12'd2050);
		drain_results();
	endtask

	// Hold the output for a long stretch while requests keep coming
	task automatic test_receiver_hold();
		set_config(1'b0, 16'd20000, 12'd8, 8'd3, 8'd2);
		for (int k = 0; k < HOLD_ITEMS; k++) begin
			if (k == 4)
				hold_asked <= hold_asked + 1;
			send_sample(SAMPLE_BITS'($urandom_range(MID_LEVEL - 60, MID_LEVEL + 60)));
		end
		drain_results();
	endtask

	// Random settings per phase; windows widen before full-range samples
	task automatic test_random_settings();
		logic [ALPHA_BITS-1:0]  alpha;
		logic [SAMPLE_BITS-1:0] span;
		logic [SAMPLE_BITS-1:0] sample;
		int unsigned            half;
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			case ($urandom_range(3))
				0:       alpha = 16'd1;
				1:       alpha = '1;
				2:       alpha = ALPHA_BITS'($urandom_range(1, 3000));
				default: alpha = ALPHA_BITS'($urandom_range(0, 65535));
			endcase
			case ($urandom_range(3))
				0:       span = SAMPLE_BITS'($urandom_range(0, 1));
				1:       span = SAMPLE_BITS'(SAMPLE_TOP);
				2:       span = SAMPLE_BITS'($urandom_range(1, 64));
				default: span = SAMPLE_BITS'($urandom_range(1, SAMPLE_TOP));
			endcase
			set_config(1'($urandom_range(1)), alpha, span, pick_step(), pick_step());
			// one phase runs with both sides always ready
			idle_pct <= (phase == 3) ? 0 : IDLE_PERCENT;
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				if (phase < 8) begin
					half   = 8 << phase;
					sample = SAMPLE_BITS'($urandom_range(MID_LEVEL - half, MID_LEVEL + half));
				end else begin
					case ($urandom_range(7))
						0:       sample = '0;
						1:       sample = '1;
						default: sample = SAMPLE_BITS'($urandom_range(0, SAMPLE_TOP));
					endcase
				end
				send_sample(sample);
			end
			drain_results();
		end
		idle_pct <= IDLE_PERCENT;
	endtask

	// Receiver: random stalls, or a long hold when asked
	always @(posedge clk) begin
		if (hold_granted != hold_asked) begin
			hold_granted  <= hold_asked;
			hold_left     <= HOLD_CYCLES;
			m_axis_tready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left     <= hold_left - 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= idle_pct);
		end
	end

	// Compare each accepted result with the oldest prediction
	always @(posedge clk) begin : check_results
		dim_result_t got;
		dim_result_t want;
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = dim_result_t'(m_axis_tdata[$bits(dim_result_t)-1:0]);
			if (dimmer_results.size() == 0) begin
				note_failure($sformatf("unexpected result drive %0d target %0d level %0d",
					got.drive, got.target, got.level));
			end else begin
				want = dimmer_results.pop_front();
				if (got.drive != want.drive || got.target != want.target
					|| got.level != want.level || got.low != want.low
					|| got.high != want.high)
					note_failure($sformatf({"result %0d: expected drive %0d target %0d ",
						"level %0d low %0d high %0d, got drive %0d target %0d level %0d ",
						"low %0d high %0d"}, results_checked, want.drive, want.target,
						want.level, want.low, want.high, got.drive, got.target, got.level,
						got.low, got.high));
			end
			results_checked++;
		end
	end

	// Stop a hung run
	initial begin : watchdog
		while (quiet_cycles < QUIET_LIMIT)
			@(posedge clk);
		$display("DONE: errors detected");
		$finish;
	end

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_first_item();
		test_frozen_corners();
		test_register_decode();
		test_sample_extremes();
		test_fast_tracking();
		test_receiver_hold();
		test_random_settings();

		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (dimmer_results.size() != 0)
			note_failure($sformatf("%0d results never arrived", dimmer_results.size()));

		$display("Checked %0d dimming results from %0d light samples: seeding, frozen corners,",
			results_checked, samples_sent);
		$display("register decode, field extremes, %0d random settings and a %0d-cycle output hold.",
			RANDOM_PHASES, HOLD_CYCLES);
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

// ----- filelist.f -----
rtl/adlp_pkg.sv
rtl/adlp_div.sv
rtl/auto_dimming_light_to_pwm.sv
tb/sv/auto_dimming_light_to_pwm_tb.sv
